// ----- src/bmp_stream_pixel_decoder_top_macros.svh -----
// Assertion macros for the bitmap decoder.
// Used by the top level; needs clk and arst_n in scope.
`ifndef BMP_STREAM_PIXEL_DECODER_TOP_MACROS_SVH
`define BMP_STREAM_PIXEL_DECODER_TOP_MACROS_SVH

// Same-cycle implication.
`define BMP_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/bmp_dec_pkg.sv -----
// Shared types, constants and helpers for the bitmap stream decoder.
// No dependencies.
package bmp_dec_pkg;

	localparam int MAX_DIMENSION_DEF = 4096;

	localparam logic [15:0] BMP_SIGNATURE = 16'd19778;
	localparam logic [15:0] PLANES_ONE    = 16'd1;
	localparam logic [15:0] DEPTH_16      = 16'd16;
	localparam logic [15:0] DEPTH_24      = 16'd24;
	localparam logic [15:0] DEPTH_32      = 16'd32;
	localparam logic [31:0] COMP_NONE     = 32'd0;
	localparam logic [31:0] COMP_MASKS    = 32'd3;
	localparam logic [31:0] INFO_BASE     = 32'd20;
	localparam logic [31:0] OFFSET_BASE   = 32'd34;
	localparam logic [31:0] MASK_BYTES    = 32'd12;

	// header byte positions at which a field completes
	localparam logic [31:0] POS_SIG    = 32'd1;
	localparam logic [31:0] POS_OFFSET = 32'd13;
	localparam logic [31:0] POS_INFO   = 32'd17;
	localparam logic [31:0] POS_WIDTH  = 32'd21;
	localparam logic [31:0] POS_HEIGHT = 32'd25;
	localparam logic [31:0] POS_PLANES = 32'd27;
	localparam logic [31:0] POS_DEPTH  = 32'd29;
	localparam logic [31:0] POS_COMP   = 32'd33;

	// default 5-5-5 masks and their top bit (shift + run of ones)
	localparam logic [31:0] MASK_R_DEF = 32'h7c00;
	localparam logic [31:0] MASK_G_DEF = 32'h03e0;
	localparam logic [31:0] MASK_B_DEF = 32'h001f;
	localparam logic [5:0]  TOP_R_DEF  = 6'd15;
	localparam logic [5:0]  TOP_G_DEF  = 6'd10;
	localparam logic [5:0]  TOP_B_DEF  = 6'd5;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SKIP,
		PH_MASKS,
		PH_DATA,
		PH_IDLE
	} phase_t;

	typedef enum logic [2:0] {
		KIND_PIXEL      = 3'd0,
		KIND_HEADER     = 3'd1,
		KIND_BAD_SIG    = 3'd2,
		KIND_BAD_PLANES = 3'd3,
		KIND_BAD_DEPTH  = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// pixel format as seen by the pixel unit
	typedef struct packed {
		logic [2:0]  bpp;
		logic [31:0] mask_r;
		logic [31:0] mask_g;
		logic [31:0] mask_b;
		logic [5:0]  top_r;
		logic [5:0]  top_g;
		logic [5:0]  top_b;
	} pix_fmt_t;

	// Position just above the lowest run of ones (32 when it reaches the top
	// or the mask is zero).
	function automatic logic [5:0] mask_top(input logic [31:0] m);
		logic [31:0] inv;
		logic [31:0] low;
		logic [5:0]  idx;
		inv = ~(m | (m - 32'd1));
		low = inv & (~inv + 32'd1);
		idx = '0;
		for (int i = 0; i < 32; i++) begin
			if (low[i]) idx = idx | 6'(i);
		end
		if (inv == 32'd0) idx = 6'd32;
		return idx;
	endfunction

endpackage

// ----- src/bmp_dec_pixel.sv -----
// Pixel formatter: turns assembled pixel bytes into RGB for 16/24/32-bit.
// Depends on bmp_dec_pkg.
module bmp_dec_pixel
	import bmp_dec_pkg::*;
(
	input  logic [31:0] fa,
	input  pix_fmt_t    fmt,
	output rgb_t        rgb
);

	// (field & mask) aligned so the mask's top bit lands at bit 8
	function automatic logic [7:0] chan(input logic [15:0] tmp, input logic [31:0] m,
		input logic [5:0] top);
		logic [15:0] v;
		logic [15:0] r;
		logic [23:0] l;
		v = tmp & m[15:0];
		r = v >> (top - 6'd8);
		l = {8'd0, v} << (6'd8 - top);
		return (top >= 6'd8) ? r[7:0] : l[7:0];
	endfunction

	always_comb begin
		unique case (fmt.bpp)
			3'd2: begin
				rgb.red   = chan(fa[15:0], fmt.mask_r, fmt.top_r);
				rgb.green = chan(fa[15:0], fmt.mask_g, fmt.top_g);
				rgb.blue  = chan(fa[15:0], fmt.mask_b, fmt.top_b);
			end
			3'd3: begin
				rgb.red   = fa[23:16];
				rgb.green = fa[15:8];
				rgb.blue  = fa[7:0];
			end
			default: begin
				rgb.red   = fa[15:8];
				rgb.green = fa[23:16];
				rgb.blue  = fa[31:24];
			end
		endcase
	end

endmodule

// ----- src/bmp_stream_pixel_decoder_top.sv -----
// Bitmap stream decoder top level: input register, header/data parser, result register.
// Depends on bmp_dec_pkg, bmp_dec_pixel and the macros header.
//
// Takes one file byte per transfer and can accept a byte in every cycle; a
// byte's result (if any) is carried by the input register and then the
// result register, and the input keeps flowing while a result waits as
// long as the result register is free or drained in the same cycle. Mask
// shifts are worked out as each mask arrives, so no byte waits on them.
// tuser bit 0 on the input marks the first byte of a file and restarts
// parsing. On the output tuser carries the result kind and tlast marks the
// last pixel (or the header result of an empty image).
// No clearing pass is needed after reset.
`include "bmp_stream_pixel_decoder_top_macros.svh"

module bmp_stream_pixel_decoder_top
	import bmp_dec_pkg::*;
#(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] start_of_file
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // red, green, blue, pixel_column, pixel_row,
	                               // frame_width, frame_height, zero fill
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast    // end_of_image
);

	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
	localparam int ROW_W = $clog2(4 * MAX_DIMENSION + 1);

	typedef struct packed {
		kind_t       kind;
		rgb_t        rgb;
		logic [11:0] col;
		logic [11:0] row;
		logic [12:0] w;
		logic [12:0] h;
		logic        eoi;
	} result_t;

	// input stage
	logic       in_valid_s1;
	logic [7:0] in_data_s1;
	logic       in_sof_s1;
	logic       adv;
	logic       fire;

	// parser state
	phase_t             phase_q, c_phase, n_phase;
	logic [31:0]        pos_q, c_pos, n_pos;
	logic [31:0]        fa_q, c_fa, n_fa;
	logic [31:0]        off_q, c_off, n_off;
	logic [31:0]        info_q, c_info, n_info;
	logic [DIM_W-1:0]   w_q, c_w, n_w;
	logic [DIM_W-1:0]   h_q, c_h, n_h;
	logic [15:0]        depth_q, c_depth, n_depth;
	logic [31:0]        comp_q, c_comp, n_comp;
	logic [2:0]         bpp_q, c_bpp, n_bpp;
	logic [ROW_W-1:0]   rowlen_q, c_rowlen, n_rowlen;
	logic [ROW_W-1:0]   padded_q, c_padded, n_padded;
	logic [31:0]        mask_q [3];
	logic [31:0]        c_mask [3];
	logic [31:0]        n_mask [3];
	logic [5:0]         top_q [3];
	logic [5:0]         c_top [3];
	logic [5:0]         n_top [3];
	logic [DIM_W-1:0]   col_q, c_col, n_col;
	logic [DIM_W-1:0]   row_q, c_row, n_row;
	logic [ROW_W-1:0]   rb_q, c_rb, n_rb;
	logic [2:0]         pb_q, c_pb, n_pb;

	// working values
	logic [31:0]        fa_sh;
	logic [31:0]        fa_or;
	logic [31:0]        skip;
	logic [DIM_W-1:0]   dim;
	logic [ROW_W:0]     rl;
	logic [2:0]         pb1;
	logic [ROW_W-1:0]   rb1;
	logic [31:0]        pos_dec;
	logic               go_after;
	logic               go_begin;
	logic               depth_ok;
	logic               res_valid;
	result_t            res;
	result_t            out_q;
	logic               out_valid_q;
	pix_fmt_t           fmt;
	rgb_t               pix_rgb;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !in_valid_s1 || adv;
	assign fire     = in_valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_data_s1 <= s_tdata;
			in_sof_s1  <= s_tuser[0];
		end
	end

	assign fmt.bpp    = c_bpp;
	assign fmt.mask_r = c_mask[0];
	assign fmt.mask_g = c_mask[1];
	assign fmt.mask_b = c_mask[2];
	assign fmt.top_r  = c_top[0];
	assign fmt.top_g  = c_top[1];
	assign fmt.top_b  = c_top[2];

	bmp_dec_pixel u_pixel (
		.fa  (fa_or),
		.fmt (fmt),
		.rgb (pix_rgb)
	);

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [31:0] v);
		if (v[31] || v == 32'd0) return '0;
		if (v > 32'(MAX_DIMENSION)) return DIM_W'(MAX_DIMENSION);
		return v[DIM_W-1:0];
	endfunction

	function automatic logic [31:0] skip_len(input logic [31:0] v, input logic [31:0] base);
		if (v[31] || v <= base) return 32'd0;
		return v - base;
	endfunction

	// a start-of-file byte sees the post-reset state
	always_comb begin
		c_phase  = in_sof_s1 ? PH_HEADER : phase_q;
		c_pos    = in_sof_s1 ? '0 : pos_q;
		c_fa     = in_sof_s1 ? '0 : fa_q;
		c_off    = in_sof_s1 ? '0 : off_q;
		c_info   = in_sof_s1 ? '0 : info_q;
		c_w      = in_sof_s1 ? '0 : w_q;
		c_h      = in_sof_s1 ? '0 : h_q;
		c_depth  = in_sof_s1 ? '0 : depth_q;
		c_comp   = in_sof_s1 ? '0 : comp_q;
		c_bpp    = in_sof_s1 ? '0 : bpp_q;
		c_rowlen = in_sof_s1 ? '0 : rowlen_q;
		c_padded = in_sof_s1 ? '0 : padded_q;
		c_mask[0] = in_sof_s1 ? MASK_R_DEF : mask_q[0];
		c_mask[1] = in_sof_s1 ? MASK_G_DEF : mask_q[1];
		c_mask[2] = in_sof_s1 ? MASK_B_DEF : mask_q[2];
		c_top[0]  = in_sof_s1 ? TOP_R_DEF : top_q[0];
		c_top[1]  = in_sof_s1 ? TOP_G_DEF : top_q[1];
		c_top[2]  = in_sof_s1 ? TOP_B_DEF : top_q[2];
		c_col    = in_sof_s1 ? '0 : col_q;
		c_row    = in_sof_s1 ? '0 : row_q;
		c_rb     = in_sof_s1 ? '0 : rb_q;
		c_pb     = in_sof_s1 ? '0 : pb_q;
	end

	always_comb begin
		n_phase  = c_phase;
		n_pos    = c_pos;
		n_fa     = c_fa;
		n_off    = c_off;
		n_info   = c_info;
		n_w      = c_w;
		n_h      = c_h;
		n_depth  = c_depth;
		n_comp   = c_comp;
		n_bpp    = c_bpp;
		n_rowlen = c_rowlen;
		n_padded = c_padded;
		n_mask   = c_mask;
		n_top    = c_top;
		n_col    = c_col;
		n_row    = c_row;
		n_rb     = c_rb;
		n_pb     = c_pb;
		res       = '0;
		res_valid = 1'b0;
		go_after  = 1'b0;
		go_begin  = 1'b0;
		fa_sh    = {in_data_s1, c_fa[31:8]};
		fa_or    = c_fa | ({24'd0, in_data_s1} << {c_pb[1:0], 3'b000});
		dim      = clamp_dim(fa_sh);
		depth_ok = (c_depth == DEPTH_16) || (c_depth == DEPTH_24) || (c_depth == DEPTH_32);
		skip     = ((fa_sh == COMP_NONE) || (fa_sh == COMP_MASKS)) ?
			skip_len(c_info, INFO_BASE) : skip_len(c_off, OFFSET_BASE);
		unique case (c_depth)
			DEPTH_16: rl = (ROW_W + 1)'({c_w, 1'b0});
			DEPTH_24: rl = (ROW_W + 1)'({c_w, 1'b0}) + (ROW_W + 1)'(c_w);
			default:  rl = (ROW_W + 1)'({c_w, 2'b00});
		endcase
		pb1     = c_pb + 3'd1;
		rb1     = c_rb + ROW_W'(1);
		pos_dec = (c_pos != 32'd0) ? c_pos - 32'd1 : c_pos;

		unique case (c_phase)
			PH_HEADER: begin
				n_fa  = fa_sh;
				n_pos = c_pos + 32'd1;
				priority case (c_pos)
					POS_SIG: begin
						if (fa_sh[31:16] != BMP_SIGNATURE) begin
							res.kind  = KIND_BAD_SIG;
							res_valid = 1'b1;
							n_phase   = PH_IDLE;
						end
					end
					POS_OFFSET: n_off  = fa_sh;
					POS_INFO:   n_info = fa_sh;
					POS_WIDTH:  n_w    = dim;
					POS_HEIGHT: n_h    = dim;
					POS_PLANES: begin
						if (fa_sh[31:16] != PLANES_ONE) begin
							res.kind  = KIND_BAD_PLANES;
							res_valid = 1'b1;
							n_phase   = PH_IDLE;
						end
					end
					POS_DEPTH: n_depth = fa_sh[31:16];
					POS_COMP: begin
						n_comp    = fa_sh;
						res_valid = 1'b1;
						if (!depth_ok) begin
							res.kind = KIND_BAD_DEPTH;
							n_phase  = PH_IDLE;
						end else begin
							res.kind = KIND_HEADER;
							res.w    = 13'(c_w);
							res.h    = 13'(c_h);
							n_bpp    = c_depth[5:3];
							n_rowlen = rl[ROW_W-1:0];
							n_padded = ROW_W'((rl + (ROW_W + 1)'(3)) & ~(ROW_W + 1)'(3));
							if (c_w == '0 || c_h == '0) begin
								res.eoi = 1'b1;
								n_phase = PH_IDLE;
							end else if (skip != 32'd0) begin
								n_pos   = skip;
								n_phase = PH_SKIP;
							end else begin
								go_after = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			PH_SKIP: begin
				n_pos = pos_dec;
				if (pos_dec == 32'd0) go_after = 1'b1;
			end
			PH_MASKS: begin
				n_fa  = fa_sh;
				n_pos = c_pos + 32'd1;
				if (c_pos[1:0] == 2'd3 && c_pos < MASK_BYTES) begin
					n_mask[c_pos[3:2]] = fa_sh;
					n_top[c_pos[3:2]]  = mask_top(fa_sh);
				end
				if (c_pos + 32'd1 >= MASK_BYTES) go_begin = 1'b1;
			end
			PH_DATA: begin
				if (c_rb < c_rowlen) begin
					n_fa = fa_or;
					n_pb = pb1;
					if (pb1 >= c_bpp) begin
						res_valid = 1'b1;
						res.kind  = KIND_PIXEL;
						res.rgb   = pix_rgb;
						res.col   = 12'(c_col);
						res.row   = 12'(c_row);
						n_pb      = '0;
						n_fa      = '0;
						n_col     = c_col + DIM_W'(1);
						if ((DIM_W + 1)'(c_col) + (DIM_W + 1)'(1) >= (DIM_W + 1)'(c_w)
							&& (DIM_W + 1)'(c_row) + (DIM_W + 1)'(1) >= (DIM_W + 1)'(c_h)) begin
							res.eoi = 1'b1;
							n_phase = PH_IDLE;
						end
					end
				end
				if (!res.eoi) begin
					n_rb = rb1;
					if (rb1 >= c_padded) begin
						n_rb  = '0;
						n_col = '0;
						n_pb  = '0;
						n_fa  = '0;
						n_row = c_row + DIM_W'(1);
					end
				end
			end
			PH_IDLE: ;
			default: ;
		endcase

		if (go_after) begin
			if (n_comp == COMP_MASKS) begin
				n_pos   = '0;
				n_phase = PH_MASKS;
			end else begin
				go_begin = 1'b1;
			end
		end
		if (go_begin) begin
			n_col   = '0;
			n_row   = '0;
			n_rb    = '0;
			n_pb    = '0;
			n_fa    = '0;
			n_phase = PH_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			fa_q     <= '0;
			off_q    <= '0;
			info_q   <= '0;
			w_q      <= '0;
			h_q      <= '0;
			depth_q  <= '0;
			comp_q   <= '0;
			bpp_q    <= '0;
			rowlen_q <= '0;
			padded_q <= '0;
			mask_q[0] <= MASK_R_DEF;
			mask_q[1] <= MASK_G_DEF;
			mask_q[2] <= MASK_B_DEF;
			top_q[0]  <= TOP_R_DEF;
			top_q[1]  <= TOP_G_DEF;
			top_q[2]  <= TOP_B_DEF;
			col_q    <= '0;
			row_q    <= '0;
			rb_q     <= '0;
			pb_q     <= '0;
		end else if (fire) begin
			phase_q  <= n_phase;
			pos_q    <= n_pos;
			fa_q     <= n_fa;
			off_q    <= n_off;
			info_q   <= n_info;
			w_q      <= n_w;
			h_q      <= n_h;
			depth_q  <= n_depth;
			comp_q   <= n_comp;
			bpp_q    <= n_bpp;
			rowlen_q <= n_rowlen;
			padded_q <= n_padded;
			mask_q   <= n_mask;
			top_q    <= n_top;
			col_q    <= n_col;
			row_q    <= n_row;
			rb_q     <= n_rb;
			pb_q     <= n_pb;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.eoi;
	assign m_tdata  = {6'd0, out_q.h, out_q.w, out_q.row, out_q.col,
		out_q.rgb.blue, out_q.rgb.green, out_q.rgb.red};

	`BMP_ASSERT_NEXT(a_idle_after_last, fire && res_valid && res.eoi, phase_q == PH_IDLE, "parser not idle after last result")
	`BMP_ASSERT(a_nonpixel_no_pos, m_tvalid && m_tuser != KIND_PIXEL, m_tdata[47:0] == 48'd0, "non-pixel result carries pixel data")
	`BMP_ASSERT(a_pixel_no_size, m_tvalid && m_tuser == KIND_PIXEL, m_tdata[73:48] == 26'd0, "pixel result carries image size")
	`BMP_ASSERT(a_data_has_size, phase_q == PH_DATA, w_q != '0 && h_q != '0, "data phase with empty image")

endmodule

// ----- sim/bmp_stream_pixel_decoder_top_test.sv -----
// Self-checking testbench for the bitmap stream decoder top level.
// Depends on bmp_dec_pkg and bmp_stream_pixel_decoder_top; drives byte streams of whole files.
module bmp_stream_pixel_decoder_top_test;
	import bmp_dec_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [11:0] col;
		logic [11:0] row;
		logic [12:0] wid;
		logic [12:0] hgt;
		logic        eoi;
	} pix_res_t;

	typedef struct packed {
		logic [7:0] data;
		logic       sof;
		logic       fixed;
		kind_t      kind;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	// sideband for directed rows whose result is typed in
	logic        row_fixed = 1'b0;
	kind_t       row_kind = KIND_PIXEL;

	int          idle_send = 0;
	int          idle_recv = 0;
	int          errors = 0;
	int          cycles = 0;

	pix_res_t    expected_pixels[$];
	logic [8:0]  file_bytes[$];   // {sof, data}

	bmp_stream_pixel_decoder_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- decoder model state ----------------
	logic [31:0] hdr_pos, shreg, offs, info, wid, hgt, depth, comp;
	logic [31:0] masks[3];
	logic [31:0] rshift[3];
	logic [31:0] ones[3];
	logic [31:0] col, row, rbyte, pbyte;
	phase_t      phase;

	function automatic logic [31:0] clamp_dim(logic [31:0] v);
		if (v[31] || v == 0) return 0;
		if (v > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
		return v;
	endfunction

	function automatic logic [31:0] skip_of(logic [31:0] v, logic [31:0] base);
		if (v[31] || v <= base) return 0;
		return v - base;
	endfunction

	function automatic void restart_parse();
		hdr_pos = 0; shreg = 0; offs = 0; info = 0; wid = 0; hgt = 0;
		depth = 0; comp = 0;
		masks[0] = MASK_R_DEF; masks[1] = MASK_G_DEF; masks[2] = MASK_B_DEF;
		for (int k = 0; k < 3; k++) begin
			rshift[k] = 0;
			ones[k] = 0;
		end
		col = 0; row = 0; rbyte = 0; pbyte = 0;
		phase = PH_HEADER;
	endfunction

	function automatic void enter_data();
		logic [31:0] m;
		for (int k = 0; k < 3; k++) begin
			m = masks[k];
			rshift[k] = 0;
			ones[k] = 0;
			if (m != 0) begin
				while (!m[0] && rshift[k] < 32) begin
					rshift[k]++;
					m = m >> 1;
				end
				while (m[0] && ones[k] < 32) begin
					ones[k]++;
					m = m >> 1;
				end
			end
		end
		col = 0; row = 0; rbyte = 0; pbyte = 0; shreg = 0;
		phase = PH_DATA;
	endfunction

	function automatic void leave_skip();
		if (comp == COMP_MASKS) begin
			hdr_pos = 0;
			phase = PH_MASKS;
		end else begin
			enter_data();
		end
	endfunction

	function automatic logic [7:0] channel(logic [31:0] px, int k);
		logic [31:0] x;
		if (masks[k] == 0) return 0;
		x = (px & masks[k]) >> rshift[k];
		if (ones[k] > 8) x = x >> (ones[k] - 8);
		else x = x << (8 - ones[k]);
		return x[7:0];
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic sof,
			output logic got, output pix_res_t r);
		logic [31:0] p, s, bpp, rowd, padded, px;
		got = 1'b0;
		r = '0;
		if (sof) restart_parse();
		case (phase)
		PH_HEADER: begin
			p = hdr_pos;
			shreg = {b, shreg[31:8]};
			hdr_pos++;
			case (p)
			POS_SIG: if (shreg[31:16] != BMP_SIGNATURE) begin
				r.kind = KIND_BAD_SIG; phase = PH_IDLE; got = 1'b1;
			end
			POS_OFFSET: offs = shreg;
			POS_INFO:   info = shreg;
			POS_WIDTH:  wid = clamp_dim(shreg);
			POS_HEIGHT: hgt = clamp_dim(shreg);
			POS_PLANES: if (shreg[31:16] != PLANES_ONE) begin
				r.kind = KIND_BAD_PLANES; phase = PH_IDLE; got = 1'b1;
			end
			POS_DEPTH:  depth = {16'd0, shreg[31:16]};
			POS_COMP: begin
				comp = shreg;
				got = 1'b1;
				if (depth != DEPTH_16 && depth != DEPTH_24 && depth != DEPTH_32) begin
					r.kind = KIND_BAD_DEPTH; phase = PH_IDLE;
				end else begin
					r.kind = KIND_HEADER;
					r.wid = wid[12:0];
					r.hgt = hgt[12:0];
					if (wid == 0 || hgt == 0) begin
						r.eoi = 1'b1; phase = PH_IDLE;
					end else begin
						s = (comp == COMP_NONE || comp == COMP_MASKS) ?
							skip_of(info, INFO_BASE) : skip_of(offs, OFFSET_BASE);
						if (s != 0) begin
							hdr_pos = s; phase = PH_SKIP;
						end else begin
							leave_skip();
						end
					end
				end
			end
			default: ;
			endcase
		end
		PH_SKIP: begin
			if (hdr_pos > 0) hdr_pos--;
			if (hdr_pos == 0) leave_skip();
		end
		PH_MASKS: begin
			p = hdr_pos;
			shreg = {b, shreg[31:8]};
			hdr_pos++;
			if (p[1:0] == 2'd3 && p < MASK_BYTES) masks[p >> 2] = shreg;
			if (hdr_pos >= MASK_BYTES) enter_data();
		end
		PH_DATA: begin
			bpp = depth >> 3;
			rowd = wid * bpp;
			padded = (rowd + 3) & ~32'd3;
			if (rbyte < rowd) begin
				shreg = shreg | (32'(b) << ((pbyte & 3) * 8));
				pbyte++;
				if (pbyte >= bpp) begin
					px = shreg;
					if (bpp == 2) begin
						r.red = channel({16'd0, px[15:0]}, 0);
						r.green = channel({16'd0, px[15:0]}, 1);
						r.blue = channel({16'd0, px[15:0]}, 2);
					end else if (bpp == 3) begin
						r.red = px[23:16]; r.green = px[15:8]; r.blue = px[7:0];
					end else begin
						r.red = px[15:8]; r.green = px[23:16]; r.blue = px[31:24];
					end
					r.kind = KIND_PIXEL;
					r.col = col[11:0];
					r.row = row[11:0];
					got = 1'b1;
					pbyte = 0;
					shreg = 0;
					if (col + 1 >= wid && row + 1 >= hgt) begin
						r.eoi = 1'b1; phase = PH_IDLE;
					end else begin
						col++;
					end
				end
			end
			if (phase == PH_DATA) begin
				rbyte++;
				if (rbyte >= padded) begin
					rbyte = 0; col = 0; pbyte = 0; shreg = 0;
					row++;
				end
			end
		end
		default: ;
		endcase
	endtask

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		pix_res_t got_r, want;
		logic     got;
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				$error("result transfer with nothing expected, kind %0d", m_tuser);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				got_r.kind = kind_t'(m_tuser);
				got_r.red = m_tdata[7:0];
				got_r.green = m_tdata[15:8];
				got_r.blue = m_tdata[23:16];
				got_r.col = m_tdata[35:24];
				got_r.row = m_tdata[47:36];
				got_r.wid = m_tdata[60:48];
				got_r.hgt = m_tdata[73:61];
				got_r.eoi = m_tlast;
				if (got_r.kind != want.kind) begin
					$error("kind: expected %0d actual %0d", want.kind, got_r.kind); errors++;
				end
				if (got_r.red != want.red) begin
					$error("red: expected %0d actual %0d", want.red, got_r.red); errors++;
				end
				if (got_r.green != want.green) begin
					$error("green: expected %0d actual %0d", want.green, got_r.green); errors++;
				end
				if (got_r.blue != want.blue) begin
					$error("blue: expected %0d actual %0d", want.blue, got_r.blue); errors++;
				end
				if (got_r.col != want.col) begin
					$error("pixel_column: expected %0d actual %0d", want.col, got_r.col);
					errors++;
				end
				if (got_r.row != want.row) begin
					$error("pixel_row: expected %0d actual %0d", want.row, got_r.row); errors++;
				end
				if (got_r.wid != want.wid) begin
					$error("frame_width: expected %0d actual %0d", want.wid, got_r.wid);
					errors++;
				end
				if (got_r.hgt != want.hgt) begin
					$error("frame_height: expected %0d actual %0d", want.hgt, got_r.hgt);
					errors++;
				end
				if (got_r.eoi != want.eoi) begin
					$error("end_of_image: expected %0d actual %0d", want.eoi, got_r.eoi);
					errors++;
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			decode_byte(s_tdata, s_tuser[0], got, got_r);
			if (row_fixed) begin
				want = '0;
				want.kind = row_kind;
				expected_pixels.push_back(want);
			end else if (got) begin
				expected_pixels.push_back(got_r);
			end
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= idle_recv);

	// ---------------- stimulus ----------------
	task automatic send_byte(input logic [7:0] b, input logic sof, input logic fixed,
			input kind_t k);
		while ($urandom_range(99) < idle_send) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= sof;
		row_fixed <= fixed;
		row_kind <= k;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic void put_le(logic [31:0] v, int n);
		for (int i = 0; i < n; i++) file_bytes.push_back({1'b0, v[8*i +: 8]});
	endfunction

	function automatic logic [31:0] pick_mask();
		case ($urandom_range(7))
		0: return 32'h0000f800;
		1: return 32'h000007e0;
		2: return 32'h0000001f;
		3: return 32'h0;
		4: return 32'h0000ffff;
		5: return 32'h0000fff0;
		6: return 32'h80000000;
		default: return $urandom;
		endcase
	endfunction

	// one bitmap file, mostly well formed, with random content
	function automatic void add_file();
		logic [31:0] w, h, dep, cmp, inf, off, s, bpp, rowd, padded, total;
		int   n;
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(20, 5);
			for (int i = 0; i < n; i++)
				file_bytes.push_back({1'($urandom_range(3) == 0), 8'($urandom)});
			return;
		end
		w = $urandom_range(7, 1);
		h = $urandom_range(4, 1);
		case ($urandom_range(11))
		0: w = 0;
		1: h = 32'hffffffff;
		2: begin w = 32'd5000; h = 0; end
		3: begin w = 0; h = 32'd70000; end
		4: w = 32'h80000001;
		default: ;
		endcase
		case ($urandom_range(9))
		0, 1, 2: dep = DEPTH_16;
		3, 4, 5: dep = DEPTH_24;
		6, 7: dep = DEPTH_32;
		8: dep = 32'hffff;
		default: dep = $urandom_range(15);
		endcase
		case ($urandom_range(5))
		0, 1: cmp = COMP_NONE;
		2, 3: cmp = COMP_MASKS;
		4: cmp = 32'd1;
		default: cmp = $urandom;
		endcase
		case ($urandom_range(5))
		0: inf = 32'd20;
		1: inf = 32'h80000010;
		2: inf = $urandom_range(44, 0);
		default: inf = 32'd40;
		endcase
		case ($urandom_range(5))
		0: off = 32'd34;
		1: off = 32'h90000000;
		2: off = $urandom_range(60, 0);
		default: off = 32'd54;
		endcase
		file_bytes.push_back({1'b1, ($urandom_range(15) == 0) ? 8'($urandom) : 8'h42});
		file_bytes.push_back({1'b0, ($urandom_range(15) == 0) ? 8'($urandom) : 8'h4d});
		put_le($urandom, 4);
		put_le($urandom, 4);
		put_le(off, 4);
		put_le(inf, 4);
		put_le(w, 4);
		put_le(h, 4);
		put_le(($urandom_range(15) == 0) ? $urandom : 32'd1, 2);
		put_le(dep, 2);
		put_le(cmp, 4);
		s = (cmp == COMP_NONE || cmp == COMP_MASKS) ? skip_of(inf, INFO_BASE) :
			skip_of(off, OFFSET_BASE);
		for (int i = 0; i < s; i++) file_bytes.push_back({1'b0, 8'($urandom)});
		if (cmp == COMP_MASKS) begin
			put_le(pick_mask(), 4);
			put_le(pick_mask(), 4);
			put_le(pick_mask(), 4);
		end
		w = clamp_dim(w);
		h = clamp_dim(h);
		if (w == 0 || h == 0) begin
			n = $urandom_range(3);
		end else begin
			bpp = dep >> 3;
			rowd = w * bpp;
			padded = (rowd + 3) & ~32'd3;
			total = padded * h;
			if (total > 200) total = 200;
			n = total;
			if ($urandom_range(7) == 0) n = $urandom_range(total);
			else n = n + $urandom_range(3);
		end
		for (int i = 0; i < n; i++) file_bytes.push_back({1'b0, 8'($urandom)});
	endfunction

	task automatic run_random(input int n_bytes);
		file_bytes.delete();
		while (file_bytes.size() < n_bytes) add_file();
		foreach (file_bytes[i])
			send_byte(file_bytes[i][7:0], file_bytes[i][8], 1'b0, KIND_PIXEL);
	endtask

	task automatic wait_drained();
		while (expected_pixels.size() != 0) @(posedge clk);
	endtask

	// short files hitting the signature check; bytes before any start_of_file come first
	dir_row_t dir_tab[14] = '{
		'{8'h42, 1'b0, 1'b0, KIND_PIXEL},
		'{8'h4d, 1'b0, 1'b0, KIND_PIXEL},
		'{8'hff, 1'b1, 1'b0, KIND_PIXEL},
		'{8'h00, 1'b0, 1'b1, KIND_BAD_SIG},
		'{8'h55, 1'b0, 1'b0, KIND_PIXEL},
		'{8'h42, 1'b1, 1'b0, KIND_PIXEL},
		'{8'h4e, 1'b0, 1'b1, KIND_BAD_SIG},
		'{8'h43, 1'b1, 1'b0, KIND_PIXEL},
		'{8'h4d, 1'b0, 1'b1, KIND_BAD_SIG},
		'{8'h00, 1'b1, 1'b0, KIND_PIXEL},
		'{8'h00, 1'b0, 1'b1, KIND_BAD_SIG},
		'{8'hff, 1'b1, 1'b0, KIND_PIXEL},
		'{8'hff, 1'b0, 1'b1, KIND_BAD_SIG},
		'{8'h00, 1'b0, 1'b0, KIND_PIXEL}
	};

	initial begin
		restart_parse();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// the first two rows parse as a header in progress; rows after a bad
		// signature exercise the idle state until the next file
		foreach (dir_tab[i])
			send_byte(dir_tab[i].data, dir_tab[i].sof, dir_tab[i].fixed, dir_tab[i].kind);
		row_fixed <= 1'b0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait_drained();
		idle_send = 33; idle_recv = 56;
		run_random(530);
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait_drained();
		idle_send = 56; idle_recv = 33;
		run_random(530);
		idle_send = 0; idle_recv = 0;
		run_random(530);
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_pixels.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/bmp_dec_pkg.sv
src/bmp_dec_pixel.sv
src/bmp_stream_pixel_decoder_top.sv
sim/bmp_stream_pixel_decoder_top_test.sv
